FILE: rtl/hbrc_pkg.sv
// ----------------------------------------------------------------------------
// hbrc_pkg
// Shared types and constants of the H-bridge PWM ramp and brake controller.
// ----------------------------------------------------------------------------
package hbrc_pkg;

	localparam int DUTY_BITS_DEF     = 12;
	localparam int TICK_BITS_DEF     = 16;
	localparam int BRAKE_TICKS_RESET = 50;

	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 4;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_SPEED = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_PWM_MIN     = 2'd0,
		REG_PWM_MAX     = 2'd1,
		REG_BRAKE_DUTY  = 2'd2,
		REG_BRAKE_TICKS = 2'd3
	} reg_t;

endpackage

FILE: rtl/hbrc_if.sv
// ----------------------------------------------------------------------------
// hbrc channel interfaces
// Command word and status word channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hbrc_cmd_if #(
	parameter int DUTY_BITS = hbrc_pkg::DUTY_BITS_DEF,
	parameter int TICK_BITS = hbrc_pkg::TICK_BITS_DEF
);
	import hbrc_pkg::*;

	logic                 valid;
	logic                 ready;
	op_t                  op;
	logic [DUTY_BITS-1:0] speed;
	logic                 forward;
	logic                 brake;
	logic [DUTY_BITS-1:0] step_size;
	logic [TICK_BITS-1:0] step_delay;

	modport source (output valid, op, speed, forward, brake, step_size, step_delay,
		input ready);
	modport sink (input valid, op, speed, forward, brake, step_size, step_delay,
		output ready);
endinterface

interface hbrc_res_if #(
	parameter int DUTY_BITS = hbrc_pkg::DUTY_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [DUTY_BITS-1:0] duty_a;
	logic [DUTY_BITS-1:0] duty_b;
	logic                 running;
	logic                 reverse_dir;
	logic [DUTY_BITS-1:0] speed_now;
	logic                 braking;
	logic                 ramping;
	logic                 rejected;

	modport source (output valid, duty_a, duty_b, running, reverse_dir, speed_now,
		braking, ramping, rejected, input ready);
	modport sink (input valid, duty_a, duty_b, running, reverse_dir, speed_now,
		braking, ramping, rejected, output ready);
endinterface

FILE: rtl/hbridge_pwm_ramp_brake_controller_unit.sv
// ----------------------------------------------------------------------------
// hbridge_pwm_ramp_brake_controller_unit
// H-bridge PWM controller: start, stop with braking pulse, ramped speed change.
// ----------------------------------------------------------------------------
// Usage
//   cmd carries one word per tick or command (tick, start, stop, change speed).
//   res returns exactly one status word per accepted command word: leg duties,
//   running, direction, current duty, braking, ramping and rejected flags.
//   The APB port holds pwm_min, pwm_max, brake_duty and brake_ticks at byte
//   addresses 0, 4, 8 and 12; write only while no word is in flight.
// Timing
//   The state update and the status word are computed from the accepted
//   word in the cycle it is taken (clamp, one add and compare per ramp
//   step) and registered in the status register.
//   Throughput is one word per cycle while res.ready is high or no status word waits.
// Reset
//   arst_n clears the motor state (stopped, duty 0, step 1) and loads the
//   register defaults; the status register is empty.
// Stall
//   While res.ready is low and a status word waits, cmd.ready drops; a word
//   is taken in the same cycle the waiting status word leaves.
// ----------------------------------------------------------------------------
module hbridge_pwm_ramp_brake_controller_unit #(
	parameter int DUTY_BITS = hbrc_pkg::DUTY_BITS_DEF,
	parameter int TICK_BITS = hbrc_pkg::TICK_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	hbrc_cmd_if.sink                             cmd,
	hbrc_res_if.source                           res,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [hbrc_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [hbrc_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [hbrc_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                 pready
);
	import hbrc_pkg::*;

	typedef logic [DUTY_BITS-1:0] duty_t;
	typedef logic [TICK_BITS-1:0] tick_t;

	// configuration
	duty_t pwm_min_q, pwm_max_q, brake_duty_q;
	tick_t brake_ticks_q;

	// motor state
	logic  run_q, dir_rev_q, brake_act_q;
	duty_t cur_q, tgt_q, step_q;
	tick_t intv_q, rcnt_q, bcnt_q;

	// next state
	logic  n_run, n_dir, n_bact, n_rej;
	duty_t n_cur, n_tgt, n_step, tgt_c, step_c;
	tick_t n_intv, n_rcnt, n_bcnt;

	// status register
	logic  res_valid_q;
	duty_t res_da_q, res_db_q, res_speed_q;
	logic  res_run_q, res_rev_q, res_brk_q, res_ramp_q, res_rej_q;

	logic  cmd_acc, cfg_wr;
	reg_t  reg_sel;

	function automatic duty_t clamp_duty(input duty_t v, input duty_t lo, input duty_t hi);
		if (v < lo)
			return lo;
		else if (v > hi)
			return hi;
		else
			return v;
	endfunction

	function automatic duty_t ramp_next(input duty_t cur, input duty_t tgt, input duty_t step);
		logic [DUTY_BITS:0] up;
		up = {1'b0, cur} + {1'b0, step};
		if (cur < tgt)
			return (up > {1'b0, tgt}) ? tgt : up[DUTY_BITS-1:0];
		else if (cur > tgt)
			return ((cur - tgt) <= step) ? tgt : duty_t'(cur - step);
		else
			return cur;
	endfunction

	assign cmd.ready = !res_valid_q || res.ready;
	assign cmd_acc   = cmd.valid && cmd.ready;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_sel = reg_t'(paddr[APB_ADDR_BITS-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_min_q     <= '0;
			pwm_max_q     <= '1;
			brake_duty_q  <= duty_t'(1) << (DUTY_BITS - 1);
			brake_ticks_q <= tick_t'(BRAKE_TICKS_RESET);
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_PWM_MIN:     pwm_min_q     <= pwdata[DUTY_BITS-1:0];
				REG_PWM_MAX:     pwm_max_q     <= pwdata[DUTY_BITS-1:0];
				REG_BRAKE_DUTY:  brake_duty_q  <= pwdata[DUTY_BITS-1:0];
				REG_BRAKE_TICKS: brake_ticks_q <= pwdata[TICK_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_PWM_MIN:     prdata = APB_DATA_BITS'(pwm_min_q);
			REG_PWM_MAX:     prdata = APB_DATA_BITS'(pwm_max_q);
			REG_BRAKE_DUTY:  prdata = APB_DATA_BITS'(brake_duty_q);
			REG_BRAKE_TICKS: prdata = APB_DATA_BITS'(brake_ticks_q);
			default:         prdata = '0;
		endcase
	end

	// ---------------- next state ----------------
	always_comb begin
		n_run  = run_q;
		n_dir  = dir_rev_q;
		n_cur  = cur_q;
		n_tgt  = tgt_q;
		n_step = step_q;
		n_intv = intv_q;
		n_rcnt = rcnt_q;
		n_bact = brake_act_q;
		n_bcnt = bcnt_q;
		n_rej  = 1'b0;
		tgt_c  = clamp_duty(cmd.speed, pwm_min_q, pwm_max_q);
		step_c = (cmd.step_size == '0) ? duty_t'(1) : cmd.step_size;
		case (cmd.op)
			OP_TICK: begin
				if (brake_act_q) begin
					n_bcnt = bcnt_q - tick_t'(1);
					if (n_bcnt == '0) begin
						n_bact = 1'b0;
						n_dir  = 1'b0;
					end
				end else if (run_q && cur_q != tgt_q && rcnt_q != '0) begin
					n_rcnt = rcnt_q - tick_t'(1);
					if (n_rcnt == '0) begin
						n_cur = ramp_next(cur_q, tgt_q, step_q);
						if (n_cur != tgt_q)
							n_rcnt = intv_q;
					end
				end
			end
			OP_START: begin
				n_bact = 1'b0;
				n_bcnt = '0;
				n_run  = 1'b1;
				n_dir  = !cmd.forward;
				n_cur  = tgt_c;
				n_tgt  = tgt_c;
				n_rcnt = '0;
			end
			OP_STOP: begin
				n_run  = 1'b0;
				n_cur  = '0;
				n_tgt  = '0;
				n_rcnt = '0;
				// braking pulse only from a running motor
				if (cmd.brake && run_q && brake_ticks_q != '0) begin
					n_bact = 1'b1;
					n_bcnt = brake_ticks_q;
				end else begin
					n_bact = 1'b0;
					n_bcnt = '0;
					n_dir  = 1'b0;
				end
			end
			OP_SPEED: begin
				if (!run_q) begin
					n_rej = 1'b1;
				end else begin
					n_tgt  = tgt_c;
					n_step = step_c;
					n_intv = cmd.step_delay;
					n_rcnt = '0;
					if (cmd.step_delay == '0) begin
						n_cur = tgt_c;
					end else if (cur_q != tgt_c) begin
						n_cur = ramp_next(cur_q, tgt_c, step_c);
						if (n_cur != tgt_c)
							n_rcnt = cmd.step_delay;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			dir_rev_q   <= 1'b0;
			cur_q       <= '0;
			tgt_q       <= '0;
			step_q      <= duty_t'(1);
			intv_q      <= '0;
			rcnt_q      <= '0;
			brake_act_q <= 1'b0;
			bcnt_q      <= '0;
		end else if (cmd_acc) begin
			run_q       <= n_run;
			dir_rev_q   <= n_dir;
			cur_q       <= n_cur;
			tgt_q       <= n_tgt;
			step_q      <= n_step;
			intv_q      <= n_intv;
			rcnt_q      <= n_rcnt;
			brake_act_q <= n_bact;
			bcnt_q      <= n_bcnt;
		end
	end

	// ---------------- status register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd_acc)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			// braking drives the opposite leg, running drives the chosen one
			if (n_bact) begin
				res_da_q <= n_dir ? brake_duty_q : '0;
				res_db_q <= n_dir ? '0 : brake_duty_q;
			end else if (n_run) begin
				res_da_q <= n_dir ? '0 : n_cur;
				res_db_q <= n_dir ? n_cur : '0;
			end else begin
				res_da_q <= '0;
				res_db_q <= '0;
			end
			res_run_q   <= n_run;
			res_rev_q   <= n_dir;
			res_speed_q <= n_cur;
			res_brk_q   <= n_bact;
			res_ramp_q  <= n_run && (n_cur != n_tgt);
			res_rej_q   <= n_rej;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.duty_a      = res_da_q;
	assign res.duty_b      = res_db_q;
	assign res.running     = res_run_q;
	assign res.reverse_dir = res_rev_q;
	assign res.speed_now   = res_speed_q;
	assign res.braking     = res_brk_q;
	assign res.ramping     = res_ramp_q;
	assign res.rejected    = res_rej_q;

`ifndef SYNTHESIS
	a_brake_not_running: assert property (@(posedge clk) disable iff (!arst_n)
		brake_act_q |-> !run_q)
		else $error("braking while running");

	a_stopped_duty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> (cur_q == '0 && tgt_q == '0))
		else $error("stopped motor with nonzero duty");

	a_ramp_count_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(rcnt_q != '0) |-> (run_q && cur_q != tgt_q))
		else $error("ramp counter live without a pending ramp");

	a_stop_clears_run: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && cmd.op == OP_STOP) |=> !run_q)
		else $error("stop left the motor running");

	a_word_per_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> res_valid_q)
		else $error("accepted word produced no status word");
`endif

endmodule
